>>> src/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants for the servo slew follower.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int unsigned POS_W    = 8;
  localparam int unsigned ELAPSE_W = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [POS_W-1:0]    NUDGE_STEP   = 8'd3;
  localparam logic [POS_W-1:0]    NUDGE_LIMIT  = 8'd177;
  localparam logic [ELAPSE_W-1:0] ELAPSED_MAX  = 9'd511;

  localparam logic [7:0] RST_STEP_PERIOD = 8'd20;
  localparam logic [7:0] RST_DEFAULT_MIN = 8'd45;
  localparam logic [7:0] RST_DEFAULT_MAX = 8'd135;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_SET_STATE     = 3'd1,
    OP_INCREMENT     = 3'd2,
    OP_DECREMENT     = 3'd3,
    OP_SET_MIN       = 3'd4,
    OP_SET_MAX       = 3'd5,
    OP_LOAD_DEFAULTS = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD     = 3'd0,
    CFG_DEFAULT_MIN     = 3'd1,
    CFG_DEFAULT_MAX     = 3'd2,
    CFG_TURN_OFF_ENABLE = 3'd3,
    CFG_RELAY_ENABLE    = 3'd4,
    CFG_DRIVE_ENABLE    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] step_period;
    logic [7:0] default_min;
    logic [7:0] default_max;
    logic       turn_off_enable;
    logic       relay_enable;
    logic       drive_enable;
  } cfg_t;

  typedef struct packed {
    op_t              opcode;
    logic [POS_W-1:0] operand;
  } item_t;

  typedef struct packed {
    logic             drive_attached;
    logic             relay_level;
    logic             drive_write;
    logic             moved;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

>>> src/ssf_cfg.sv
// ----------------------------------------------------------------------------
// ssf_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ssf_cfg
  import ssf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_PERIOD:     cfg_nxt.step_period     = cfg_wdata;
        CFG_DEFAULT_MIN:     cfg_nxt.default_min     = cfg_wdata;
        CFG_DEFAULT_MAX:     cfg_nxt.default_max     = cfg_wdata;
        CFG_TURN_OFF_ENABLE: cfg_nxt.turn_off_enable = cfg_wdata[0];
        CFG_RELAY_ENABLE:    cfg_nxt.relay_enable    = cfg_wdata[0];
        CFG_DRIVE_ENABLE:    cfg_nxt.drive_enable    = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period     <= RST_STEP_PERIOD;
      cfg_r.default_min     <= RST_DEFAULT_MIN;
      cfg_r.default_max     <= RST_DEFAULT_MAX;
      cfg_r.turn_off_enable <= 1'b0;
      cfg_r.relay_enable    <= 1'b0;
      cfg_r.drive_enable    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/ssf_core.sv
// ----------------------------------------------------------------------------
// ssf_core
// Follower state and the single-pass update for one tick or command.
// ----------------------------------------------------------------------------
module ssf_core
  import ssf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                target_r, target_nxt;
  logic [POS_W-1:0]    low_r, low_nxt;
  logic [POS_W-1:0]    high_r, high_nxt;
  logic [ELAPSE_W-1:0] elapsed_r, elapsed_nxt;
  logic                attached_r, attached_nxt;
  logic                relay_r, relay_nxt;

  logic                tick;
  logic                step;
  logic [ELAPSE_W-1:0] elapsed_inc;
  logic [POS_W-1:0]    setpoint;
  logic [POS_W-1:0]    pos_step;
  logic                moved;
  logic signed [POS_W+1:0] diff;
  logic signed [POS_W+1:0] half;
  logic signed [POS_W+1:0] mid;
  logic                below;
  logic                swapped;

  assign tick        = (item.opcode == OP_TICK);
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign step        = tick && (elapsed_inc > {1'b0, cfg.step_period});
  assign setpoint    = target_r ? high_r : low_r;

  always_comb begin
    if (pos_r < setpoint) begin
      pos_step = pos_r + 1'b1;
    end else if (pos_r > setpoint) begin
      pos_step = pos_r - 1'b1;
    end else begin
      pos_step = pos_r;
    end
  end

  assign moved = step && (pos_r != setpoint);

  // Midpoint with the halving rounded toward zero: add one before the
  // arithmetic shift when the span is negative.
  assign diff    = $signed({2'b00, high_r}) - $signed({2'b00, low_r});
  assign half    = (diff + $signed({{(POS_W+1){1'b0}}, diff[POS_W+1]})) >>> 1;
  assign mid     = half + $signed({2'b00, low_r});
  assign below   = $signed({2'b00, pos_step}) < mid;
  assign swapped = low_r > high_r;

  always_comb begin
    pos_nxt      = pos_r;
    target_nxt   = target_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    elapsed_nxt  = elapsed_r;
    attached_nxt = attached_r;
    relay_nxt    = relay_r;
    unique case (item.opcode)
      OP_TICK: begin
        elapsed_nxt = step ? '0 : elapsed_inc;
        if (moved) begin
          pos_nxt = pos_step;
          if (pos_step != setpoint) begin
            attached_nxt = 1'b1;
          end else if (cfg.turn_off_enable) begin
            attached_nxt = 1'b0;
          end
          if (cfg.relay_enable) begin
            relay_nxt = below ^ swapped;
          end
        end
      end
      OP_SET_STATE: target_nxt = (item.operand != '0);
      OP_INCREMENT: begin
        // An increment on the high side that is out of room falls through
        // to the low endpoint.
        if (target_r && (high_r <= NUDGE_LIMIT)) begin
          high_nxt = high_r + NUDGE_STEP;
        end else if (low_r <= NUDGE_LIMIT) begin
          low_nxt = low_r + NUDGE_STEP;
        end
      end
      OP_DECREMENT: begin
        if (target_r && (high_r >= NUDGE_STEP)) begin
          high_nxt = high_r - NUDGE_STEP;
        end else if (low_r >= NUDGE_STEP) begin
          low_nxt = low_r - NUDGE_STEP;
        end
      end
      OP_SET_MIN: low_nxt = item.operand;
      OP_SET_MAX: high_nxt = item.operand;
      OP_LOAD_DEFAULTS: begin
        low_nxt  = cfg.default_min;
        high_nxt = cfg.default_max;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.position       = moved ? pos_step : '0;
    result.moved          = moved;
    result.drive_write    = moved && cfg.drive_enable;
    result.relay_level    = relay_nxt;
    result.drive_attached = attached_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      target_r   <= 1'b0;
      low_r      <= RST_DEFAULT_MIN;
      high_r     <= RST_DEFAULT_MAX;
      elapsed_r  <= '0;
      attached_r <= 1'b0;
      relay_r    <= 1'b0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      target_r   <= target_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      elapsed_r  <= elapsed_nxt;
      attached_r <= attached_nxt;
      relay_r    <= relay_nxt;
    end
  end

  // The counter clears once it passes the step period, so it never goes
  // beyond one past the largest period.
  a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r[ELAPSE_W-1] |-> (elapsed_r[ELAPSE_W-2:0] == '0))
    else $error("elapsed tick counter out of range");

  a_pos_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire || !tick) |=> $stable(pos_r))
    else $error("position changed without a tick");

  a_move_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && moved) |=> ((pos_r == $past(pos_r) + 1'b1) || (pos_r == $past(pos_r) - 1'b1)))
    else $error("position moved by more than one step");

  a_attach_short: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && moved && (pos_step != setpoint)) |=> attached_r)
    else $error("drive not attached while short of the target");

endmodule

>>> src/servo_slew_follower.sv
// ----------------------------------------------------------------------------
// servo_slew_follower
// Rate-limited servo position follower driven by ticks and commands.
// ----------------------------------------------------------------------------
//  channel | ports          | contents
//  --------+----------------+---------------------------------------------
//  in      | in_t*          | tuser: opcode; tdata: operand
//  out     | out_t*         | tdata: position, moved, drive_write,
//          |                |        relay_level, drive_attached
//  cfg     | cfg_*          | write enable, register index, write data
//
// One transaction is taken per cycle while the output is not stalled. A
// transaction waits in the input register, and the follower state and result
// are updated as it moves into the output register, so its result is offered
// once that register is loaded and is taken at an edge with out_tready high.
// Reset (synchronous, rst_n low) empties both registers and restores state.
// A stalled output holds its result; the input register still fills behind it.
// ----------------------------------------------------------------------------
module servo_slew_follower
  import ssf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] operand
  input  logic [2:0]            in_tuser,   // [2:0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [7:0] position, [8] moved,
                                            // [9] drive_write, [10] relay_level,
                                            // [11] drive_attached, [15:12] zero
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    in_fire;
  logic    advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.opcode  <= op_t'(in_tuser);
      s1_item_r.operand <= in_tdata;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  ssf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

endmodule
